### sv/dteg_pkg.sv
// Shared types, widths and constants of the drawn-table envelope generator.
package dteg_pkg;

   // Table geometry.
   localparam int TABLE_SIZE = 64;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);

   // Q.16 table position, wide enough to hold the end position itself.
   localparam int POS_W = $clog2(TABLE_SIZE + 1) + 16;
   localparam int RAW_W = POS_W - 16;
   localparam logic [POS_W-1:0] END_POS = POS_W'(TABLE_SIZE * 65536);

   // Field and register widths.
   localparam int GAIN_W     = 16;
   localparam int STEP_W     = 26;
   localparam int SCALE_W    = 24;
   localparam int MODE_W     = 3;
   localparam int INDEX_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 26;
   localparam int ADV_W      = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;

   // Interpolation fraction, signed, spans half an entry below and up to one entry above.
   localparam int FRAC_W = 18;

   // Shared arithmetic unit operand and result widths.
   localparam int ALU_A_W = 25;
   localparam int ALU_B_W = 18;
   localparam int ALU_R_W = 43;

   // Release scale divider.
   localparam int DVD_W = 32;
   localparam int CNT_W = $clog2(DVD_W);

   // Level constants.
   localparam logic [GAIN_W-1:0]  INIT_LEVEL = 16'd32768;
   localparam logic [GAIN_W-1:0]  GAIN_MAX   = 16'hFFFF;
   localparam logic [SCALE_W-1:0] SCALE_ONE  = 24'h010000;
   localparam logic [SCALE_W-1:0] SCALE_MAX  = 24'hFFFFFF;

   // Register reset values.
   localparam logic [STEP_W-1:0] ATTACK_STEP_RST  = 26'd8738;
   localparam logic [STEP_W-1:0] RELEASE_STEP_RST = 26'd4369;
   localparam logic [GAIN_W-1:0] SUSTAIN_RST      = 16'd32768;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN      = 2'd2;

   // Request modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK     = 3'd0,
      MODE_NOTE_ON  = 3'd1,
      MODE_SOFT_OFF = 3'd2,
      MODE_HARD_OFF = 3'd3,
      MODE_WR_ATT   = 3'd4,
      MODE_WR_REL   = 3'd5
   } mode_type;

   // Envelope phases.
   typedef enum logic [1:0] {
      PH_OFF     = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // Shared unit operations.
   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Operation handed to the shared unit.
   typedef struct packed {
      alu_op_type                 op;
      logic signed [ALU_A_W-1:0]  a;
      logic signed [ALU_B_W-1:0]  b;
   } alu_req_type;

   // Sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_READ   = 9'b000000010,
      ST_NEXT   = 9'b000000100,
      ST_INTERP = 9'b000001000,
      ST_SCALE  = 9'b000010000,
      ST_ROUND  = 9'b000100000,
      ST_FINISH = 9'b001000000,
      ST_DIV    = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

### sv/dteg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dteg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dteg_alu.sv
// Shared arithmetic unit: signed multiply or signed subtract.
module dteg_alu (
   input  dteg_pkg::alu_req_type                 alu_req,
   output logic signed [dteg_pkg::ALU_R_W-1:0]   alu_res
);

   logic signed [dteg_pkg::ALU_R_W-1:0] a_ext;
   logic signed [dteg_pkg::ALU_R_W-1:0] b_ext;

   // Operands are sign-extended to the full result width.
   always_comb begin
      a_ext = dteg_pkg::ALU_R_W'(alu_req.a);
      b_ext = dteg_pkg::ALU_R_W'(alu_req.b);
      unique case (alu_req.op)
         dteg_pkg::ALU_MUL: alu_res = a_ext * b_ext;
         dteg_pkg::ALU_SUB: alu_res = a_ext - b_ext;
         default:           alu_res = '0;
      endcase
   end

endmodule

### sv/drawn_table_envelope_generator_unit.sv
// Top level of the drawn-table envelope generator: sequencer, tables and state.
//
// Usage: each request on the req_ channel carries a mode (tick, note on, soft
// note off, hard note off, attack table write, release table write), a table
// entry index and a value. A tick or a hard note off yields one response on
// the rsp_ channel (gain and note_ended); the other modes yield none. The
// csr_ port writes attack_step, release_step or sustain_level, one per write.
// Requests are taken one at a time; req_stall is high while one is at work.
// A tick in off or sustain and a hard note off go straight to the done state;
// a tick in attack or release takes two table reads, then an optional
// interpolation multiply and, in release, a scale multiply, all on one shared
// multiplier. Unless sustain is zero, a soft note off holds the block while
// the release scale is found by a one-bit-a-cycle division on the shared
// unit's subtractor. Other modes do not stall the block.
// A finished response waits in an output register while a new request is
// taken; the block stalls only when a second response is ready before the
// first was taken. Reset returns to off, position zero, scale one, default
// registers and all table entries at half level (per-entry valid bits).
module drawn_table_envelope_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dteg_pkg::MODE_W-1:0]       req_mode,
   input  logic [dteg_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [dteg_pkg::GAIN_W-1:0]       req_entry_value,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dteg_pkg::GAIN_W-1:0]       rsp_gain,
   output logic                              rsp_note_ended,
   // Configuration port.
   input  logic                              csr_write,
   input  logic [dteg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dteg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int TS    = dteg_pkg::TABLE_SIZE;
   localparam int AW    = dteg_pkg::ADDR_W;
   localparam int PW    = dteg_pkg::POS_W;
   localparam int RW    = dteg_pkg::ALU_R_W;
   localparam int GW    = dteg_pkg::GAIN_W;

   // Control state.
   dteg_pkg::state_type               state_ff, state_in;
   dteg_pkg::phase_type               phase_ff, phase_in;
   logic [PW-1:0]                     pos_ff, pos_in;
   logic [GW-1:0]                     last_gain_ff, last_gain_in;
   logic [dteg_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [dteg_pkg::STEP_W-1:0]       att_step_ff, att_step_in;
   logic [dteg_pkg::STEP_W-1:0]       rel_step_ff, rel_step_in;
   logic [GW-1:0]                     sus_ff, sus_in;
   logic [TS-1:0]                     att_vld_ff, att_vld_in;
   logic [TS-1:0]                     rel_vld_ff, rel_vld_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [AW-1:0]                       idx_ff, idx_in;
   logic signed [dteg_pkg::FRAC_W-1:0]  frac_ff, frac_in;
   logic [GW-1:0]                       g_ff, g_in;
   logic signed [RW-1:0]                prod_ff, prod_in;
   logic                                rd_vld_ff;
   logic [dteg_pkg::DVD_W-1:0]          dvd_ff, dvd_in;
   logic [dteg_pkg::DVD_W-1:0]          quo_ff, quo_in;
   logic [GW-1:0]                       rem_ff, rem_in;
   logic [dteg_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [GW-1:0]                       res_gain_ff, res_gain_in;
   logic                                res_end_ff, res_end_in;
   logic [GW-1:0]                       rsp_gain_ff, rsp_gain_in;
   logic                                rsp_end_ff, rsp_end_in;

   // Combinational helpers.
   logic                                req_accept;
   logic                                wr_in_range;
   logic [AW-1:0]                       wr_addr;
   logic                                att_we;
   logic                                rel_we;
   logic [AW-1:0]                       ram_addr;
   logic [GW-1:0]                       att_rd;
   logic [GW-1:0]                       rel_rd;
   logic [GW-1:0]                       tab_val;
   logic [PW-1:0]                       pos_round;
   logic [dteg_pkg::RAW_W-1:0]          idx_raw;
   logic [AW-1:0]                       idx_calc;
   logic [PW:0]                         frac_wide;
   logic [GW-1:0]                       next_val;
   logic                                has_next;
   logic signed [GW:0]                  diff;
   logic signed [RW-1:0]                prod_rnd;
   logic signed [RW-1:0]                prod_sh;
   logic signed [RW-1:0]                g_sum;
   logic [dteg_pkg::ADV_W-1:0]          pos_adv;
   logic [GW:0]                         div_shift;
   logic                                div_bit;
   dteg_pkg::alu_req_type               alu_req;
   logic signed [RW-1:0]                alu_res;

   // Shared arithmetic unit.
   dteg_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Attack and release shape tables.
   dteg_ram #(.WIDTH(GW), .DEPTH(TS)) u_att_ram (
      .clock   (clock),
      .wr_en   (att_we),
      .wr_addr (wr_addr),
      .wr_data (req_entry_value),
      .rd_addr (ram_addr),
      .rd_data (att_rd)
   );

   dteg_ram #(.WIDTH(GW), .DEPTH(TS)) u_rel_ram (
      .clock   (clock),
      .wr_en   (rel_we),
      .wr_addr (wr_addr),
      .wr_data (req_entry_value),
      .rd_addr (ram_addr),
      .rd_data (rel_rd)
   );

   // Handshake and table write decode.
   assign req_stall   = (state_ff != dteg_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign wr_in_range = (32'(req_entry_index) < 32'(TS));
   assign wr_addr     = AW'(req_entry_index);
   assign att_we      = req_accept && wr_in_range && (req_mode == dteg_pkg::MODE_WR_ATT);
   assign rel_we      = req_accept && wr_in_range && (req_mode == dteg_pkg::MODE_WR_REL);

   // A table entry never written reads as the initial level.
   assign tab_val = rd_vld_ff ? ((phase_ff == dteg_pkg::PH_ATTACK) ? att_rd : rel_rd)
                              : dteg_pkg::INIT_LEVEL;

   // Rounded, clamped table index and signed fraction from the position.
   always_comb begin
      pos_round = pos_ff + PW'(32768);
      idx_raw   = pos_round[PW-1:16];
      if (idx_raw >= dteg_pkg::RAW_W'(TS)) begin
         idx_calc = AW'(TS - 1);
      end else begin
         idx_calc = AW'(idx_raw);
      end
      frac_wide = (PW + 1)'(pos_ff) - (PW + 1)'({idx_calc, 16'h0000});
   end

   // Rounded product, arithmetic shift floors toward minus infinity.
   assign prod_rnd = prod_ff + RW'(32768);
   assign prod_sh  = prod_rnd >>> 16;
   assign g_sum    = prod_sh + RW'({1'b0, g_ff});

   // Next entry for interpolation; at the last attack entry it is sustain.
   always_comb begin
      if (idx_ff == AW'(TS - 1)) begin
         has_next = (phase_ff == dteg_pkg::PH_ATTACK);
         next_val = sus_ff;
      end else begin
         has_next = 1'b1;
         next_val = tab_val;
      end
      diff = (GW + 1)'({1'b0, next_val}) - (GW + 1)'({1'b0, g_ff});
   end

   // Position advance and divider trial subtraction inputs.
   assign pos_adv   = dteg_pkg::ADV_W'(pos_ff) +
                      dteg_pkg::ADV_W'((phase_ff == dteg_pkg::PH_ATTACK) ? att_step_ff
                                                                        : rel_step_ff);
   assign div_shift = {rem_ff, dvd_ff[dteg_pkg::DVD_W-1]};
   assign div_bit   = !alu_res[RW-1];

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      last_gain_in = last_gain_ff;
      scale_in     = scale_ff;
      att_step_in  = att_step_ff;
      rel_step_in  = rel_step_ff;
      sus_in       = sus_ff;
      att_vld_in   = att_vld_ff;
      rel_vld_in   = rel_vld_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      g_in         = g_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_gain_in  = res_gain_ff;
      res_end_in   = res_end_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_addr     = AW'(idx_ff + AW'(1));
      alu_req.op   = dteg_pkg::ALU_MUL;
      alu_req.a    = '0;
      alu_req.b    = '0;

      // Configuration writes.
      if (csr_write) begin
         unique case (csr_index)
            dteg_pkg::CSR_ATTACK_STEP:  att_step_in = csr_wdata;
            dteg_pkg::CSR_RELEASE_STEP: rel_step_in = csr_wdata;
            dteg_pkg::CSR_SUSTAIN:      sus_in      = csr_wdata[GW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         dteg_pkg::ST_IDLE: begin
            ram_addr = idx_calc;
            if (req_accept) begin
               unique case (req_mode)
                  dteg_pkg::MODE_TICK: begin
                     res_end_in = 1'b0;
                     unique case (phase_ff)
                        dteg_pkg::PH_OFF: begin
                           res_gain_in = '0;
                           state_in    = dteg_pkg::ST_DONE;
                        end
                        dteg_pkg::PH_SUSTAIN: begin
                           res_gain_in = sus_ff;
                           state_in    = dteg_pkg::ST_DONE;
                        end
                        default: begin
                           idx_in   = idx_calc;
                           frac_in  = dteg_pkg::FRAC_W'(frac_wide);
                           state_in = dteg_pkg::ST_READ;
                        end
                     endcase
                  end
                  dteg_pkg::MODE_NOTE_ON: begin
                     phase_in = dteg_pkg::PH_ATTACK;
                  end
                  dteg_pkg::MODE_SOFT_OFF: begin
                     phase_in = dteg_pkg::PH_RELEASE;
                     pos_in   = '0;
                     if (sus_ff == '0) begin
                        scale_in = dteg_pkg::SCALE_MAX;
                     end else begin
                        dvd_in   = {last_gain_ff, 16'h0000};
                        quo_in   = '0;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = dteg_pkg::ST_DIV;
                     end
                  end
                  dteg_pkg::MODE_HARD_OFF: begin
                     phase_in    = dteg_pkg::PH_OFF;
                     scale_in    = dteg_pkg::SCALE_ONE;
                     pos_in      = '0;
                     res_gain_in = '0;
                     res_end_in  = 1'b1;
                     state_in    = dteg_pkg::ST_DONE;
                  end
                  dteg_pkg::MODE_WR_ATT: begin
                     if (wr_in_range) begin
                        att_vld_in[wr_addr] = 1'b1;
                     end
                  end
                  dteg_pkg::MODE_WR_REL: begin
                     if (wr_in_range) begin
                        rel_vld_in[wr_addr] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Entry at the index arrives; the next entry is being read.
         dteg_pkg::ST_READ: begin
            g_in     = tab_val;
            state_in = dteg_pkg::ST_NEXT;
         end

         // Interpolation multiply, skipped when there is no positive next value.
         dteg_pkg::ST_NEXT: begin
            if (has_next && (next_val != '0)) begin
               alu_req.a = dteg_pkg::ALU_A_W'(diff);
               alu_req.b = frac_ff;
               prod_in   = alu_res;
               state_in  = dteg_pkg::ST_INTERP;
            end else if (phase_ff == dteg_pkg::PH_RELEASE) begin
               state_in = dteg_pkg::ST_SCALE;
            end else begin
               state_in = dteg_pkg::ST_FINISH;
            end
         end

         // Add the rounded step and clamp to the gain range.
         dteg_pkg::ST_INTERP: begin
            if (g_sum < 0) begin
               g_in = '0;
            end else if (g_sum > RW'(65535)) begin
               g_in = dteg_pkg::GAIN_MAX;
            end else begin
               g_in = g_sum[GW-1:0];
            end
            if (phase_ff == dteg_pkg::PH_RELEASE) begin
               state_in = dteg_pkg::ST_SCALE;
            end else begin
               state_in = dteg_pkg::ST_FINISH;
            end
         end

         // Release scale multiply.
         dteg_pkg::ST_SCALE: begin
            alu_req.a = dteg_pkg::ALU_A_W'({1'b0, scale_ff});
            alu_req.b = dteg_pkg::ALU_B_W'({1'b0, g_ff});
            prod_in   = alu_res;
            state_in  = dteg_pkg::ST_ROUND;
         end

         // Round the scaled gain and saturate.
         dteg_pkg::ST_ROUND: begin
            if (prod_sh > RW'(65535)) begin
               g_in = dteg_pkg::GAIN_MAX;
            end else begin
               g_in = prod_sh[GW-1:0];
            end
            state_in = dteg_pkg::ST_FINISH;
         end

         // Advance the position and handle the end of the phase.
         dteg_pkg::ST_FINISH: begin
            last_gain_in = g_ff;
            res_gain_in  = g_ff;
            res_end_in   = 1'b0;
            if (pos_adv > dteg_pkg::ADV_W'(dteg_pkg::END_POS)) begin
               pos_in = dteg_pkg::END_POS;
            end else begin
               pos_in = PW'(pos_adv);
            end
            if (pos_ff >= dteg_pkg::END_POS) begin
               if (phase_ff == dteg_pkg::PH_ATTACK) begin
                  phase_in     = dteg_pkg::PH_SUSTAIN;
                  res_gain_in  = sus_ff;
                  last_gain_in = sus_ff;
               end else begin
                  phase_in     = dteg_pkg::PH_OFF;
                  res_gain_in  = '0;
                  last_gain_in = '0;
                  scale_in     = dteg_pkg::SCALE_ONE;
                  pos_in       = '0;
                  res_end_in   = 1'b1;
               end
            end
            state_in = dteg_pkg::ST_DONE;
         end

         // One quotient bit a cycle; trial subtraction on the shared unit.
         dteg_pkg::ST_DIV: begin
            alu_req.op = dteg_pkg::ALU_SUB;
            alu_req.a  = dteg_pkg::ALU_A_W'(div_shift);
            alu_req.b  = dteg_pkg::ALU_B_W'(sus_ff);
            if (div_bit) begin
               rem_in = alu_res[GW-1:0];
            end else begin
               rem_in = div_shift[GW-1:0];
            end
            quo_in = {quo_ff[dteg_pkg::DVD_W-2:0], div_bit};
            dvd_in = {dvd_ff[dteg_pkg::DVD_W-2:0], 1'b0};
            cnt_in = cnt_ff + dteg_pkg::CNT_W'(1);
            if (cnt_ff == dteg_pkg::CNT_W'(dteg_pkg::DVD_W - 1)) begin
               if (quo_in[dteg_pkg::DVD_W-1:dteg_pkg::SCALE_W] != '0) begin
                  scale_in = dteg_pkg::SCALE_MAX;
               end else begin
                  scale_in = quo_in[dteg_pkg::SCALE_W-1:0];
               end
               state_in = dteg_pkg::ST_IDLE;
            end
         end

         // Hand the response over once the output register is free.
         dteg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = res_gain_ff;
               rsp_end_in   = res_end_ff;
               state_in     = dteg_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dteg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dteg_pkg::ST_IDLE;
         phase_ff     <= dteg_pkg::PH_OFF;
         pos_ff       <= '0;
         last_gain_ff <= '0;
         scale_ff     <= dteg_pkg::SCALE_ONE;
         att_step_ff  <= dteg_pkg::ATTACK_STEP_RST;
         rel_step_ff  <= dteg_pkg::RELEASE_STEP_RST;
         sus_ff       <= dteg_pkg::SUSTAIN_RST;
         att_vld_ff   <= '0;
         rel_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         last_gain_ff <= last_gain_in;
         scale_ff     <= scale_in;
         att_step_ff  <= att_step_in;
         rel_step_ff  <= rel_step_in;
         sus_ff       <= sus_in;
         att_vld_ff   <= att_vld_in;
         rel_vld_ff   <= rel_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      g_ff        <= g_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      res_gain_ff <= res_gain_in;
      res_end_ff  <= res_end_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_end_ff  <= rsp_end_in;
      // Valid bit of the entry read, alongside the registered table read.
      rd_vld_ff   <= (phase_ff == dteg_pkg::PH_ATTACK) ? att_vld_ff[ram_addr]
                                                       : rel_vld_ff[ram_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gain       = rsp_gain_ff;
   assign rsp_note_ended = rsp_end_ff;

endmodule

### bench/envelope_gain_checker.sv
// Checker for the envelope generator: watches requests and register writes, predicts and compares.
module envelope_gain_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [dteg_pkg::MODE_W-1:0]     req_mode,
   input  logic [dteg_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [dteg_pkg::GAIN_W-1:0]     req_entry_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [dteg_pkg::GAIN_W-1:0]     rsp_gain,
   input  logic                            rsp_note_ended,
   input  logic                            csr_write,
   input  logic [dteg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dteg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              failures,
   output int                              pending
);

   // One predicted response.
   typedef struct packed {
      logic [dteg_pkg::GAIN_W-1:0] gain;
      logic                        ended;
   } gain_result_type;

   gain_result_type awaited_gains[$];
   int              fail_count = 0;

   // Register copies.
   logic [dteg_pkg::STEP_W-1:0]  att_step;
   logic [dteg_pkg::STEP_W-1:0]  rel_step;
   logic [dteg_pkg::GAIN_W-1:0]  sus_level;

   // Envelope state.
   dteg_pkg::phase_type          env_phase;
   logic [dteg_pkg::POS_W-1:0]   position;
   logic [dteg_pkg::GAIN_W-1:0]  held_gain;
   logic [dteg_pkg::SCALE_W-1:0] rel_scale;
   logic [dteg_pkg::GAIN_W-1:0]  att_tab [dteg_pkg::TABLE_SIZE];
   logic [dteg_pkg::GAIN_W-1:0]  rel_tab [dteg_pkg::TABLE_SIZE];

   // Returns the envelope to its state after reset.
   task automatic clear_envelope();
      att_step  = dteg_pkg::ATTACK_STEP_RST;
      rel_step  = dteg_pkg::RELEASE_STEP_RST;
      sus_level = dteg_pkg::SUSTAIN_RST;
      env_phase = dteg_pkg::PH_OFF;
      position  = '0;
      held_gain = '0;
      rel_scale = dteg_pkg::SCALE_ONE;
      for (int i = 0; i < dteg_pkg::TABLE_SIZE; i++) begin
         att_tab[i] = dteg_pkg::INIT_LEVEL;
         rel_tab[i] = dteg_pkg::INIT_LEVEL;
      end
   endtask

   // Gain of the current table position in attack or release.
   function automatic logic [dteg_pkg::GAIN_W-1:0] shaped_gain();
      int                          idx;
      longint                      g;
      longint                      frac;
      longint                      nxt;
      longint                      scaled;
      bit                          has_nxt;
      logic [dteg_pkg::GAIN_W-1:0] here;
      logic [dteg_pkg::GAIN_W-1:0] ahead;
      // Round the position to the nearest entry and clamp it to the table.
      idx = (int'(position) + 32'h8000) >> 16;
      if (idx > dteg_pkg::TABLE_SIZE - 1)
         idx = dteg_pkg::TABLE_SIZE - 1;
      here    = (env_phase == dteg_pkg::PH_ATTACK) ? att_tab[idx] : rel_tab[idx];
      has_nxt = 1'b1;
      ahead   = '0;
      if (idx < dteg_pkg::TABLE_SIZE - 1) begin
         ahead = (env_phase == dteg_pkg::PH_ATTACK) ? att_tab[idx + 1] : rel_tab[idx + 1];
      end else if (env_phase == dteg_pkg::PH_ATTACK) begin
         ahead = sus_level;
      end else begin
         has_nxt = 1'b0;
      end
      g    = longint'(here);
      frac = longint'(position) - longint'(idx) * 65536;
      // Interpolate only towards a positive next value.
      if (has_nxt && ahead != '0) begin
         nxt = longint'(ahead);
         g   = g + (((nxt - g) * frac + 32768) >>> 16);
         if (g < 0)
            g = 0;
         if (g > 65535)
            g = 65535;
      end
      // The release shape is scaled by the ratio of the gain held at note-off to the sustain level.
      if (env_phase == dteg_pkg::PH_RELEASE) begin
         scaled = (g * longint'(rel_scale) + 32768) >>> 16;
         g      = (scaled > 65535) ? 65535 : scaled;
      end
      return dteg_pkg::GAIN_W'(g);
   endfunction

   // Applies one accepted request and queues the response it causes.
   task automatic predict_request(input logic [dteg_pkg::MODE_W-1:0]  mode,
                                  input logic [dteg_pkg::INDEX_W-1:0] idx,
                                  input logic [dteg_pkg::GAIN_W-1:0]  val);
      logic [dteg_pkg::ADV_W-1:0] advanced;
      logic [dteg_pkg::POS_W-1:0] start_pos;
      longint unsigned            ratio;
      gain_result_type            outcome;
      outcome = '0;
      case (mode)
         dteg_pkg::MODE_TICK: begin
            if (env_phase == dteg_pkg::PH_SUSTAIN) begin
               outcome.gain = sus_level;
            end else if (env_phase == dteg_pkg::PH_ATTACK
                         || env_phase == dteg_pkg::PH_RELEASE) begin
               start_pos = position;
               advanced  = dteg_pkg::ADV_W'(start_pos)
                         + dteg_pkg::ADV_W'((env_phase == dteg_pkg::PH_ATTACK) ? att_step
                                                                                : rel_step);
               outcome.gain = shaped_gain();
               held_gain    = outcome.gain;
               position     = (advanced > dteg_pkg::ADV_W'(dteg_pkg::END_POS))
                              ? dteg_pkg::END_POS : dteg_pkg::POS_W'(advanced);
               // The end of a phase is judged on the position before it advanced.
               if (start_pos >= dteg_pkg::END_POS) begin
                  if (env_phase == dteg_pkg::PH_ATTACK) begin
                     env_phase    = dteg_pkg::PH_SUSTAIN;
                     outcome.gain = sus_level;
                     held_gain    = sus_level;
                  end else begin
                     env_phase     = dteg_pkg::PH_OFF;
                     outcome.gain  = '0;
                     outcome.ended = 1'b1;
                     held_gain     = '0;
                     rel_scale     = dteg_pkg::SCALE_ONE;
                     position      = '0;
                  end
               end
            end
            awaited_gains.push_back(outcome);
         end
         dteg_pkg::MODE_NOTE_ON: begin
            env_phase = dteg_pkg::PH_ATTACK;
         end
         dteg_pkg::MODE_SOFT_OFF: begin
            env_phase = dteg_pkg::PH_RELEASE;
            position  = '0;
            if (sus_level == '0) begin
               rel_scale = dteg_pkg::SCALE_MAX;
            end else begin
               ratio = {held_gain, 16'h0000};
               ratio = ratio / sus_level;
               rel_scale = (ratio > dteg_pkg::SCALE_MAX) ? dteg_pkg::SCALE_MAX
                                                         : dteg_pkg::SCALE_W'(ratio);
            end
         end
         dteg_pkg::MODE_HARD_OFF: begin
            env_phase     = dteg_pkg::PH_OFF;
            rel_scale     = dteg_pkg::SCALE_ONE;
            position      = '0;
            outcome.ended = 1'b1;
            awaited_gains.push_back(outcome);
         end
         dteg_pkg::MODE_WR_ATT: begin
            if (idx < dteg_pkg::TABLE_SIZE)
               att_tab[idx] = val;
         end
         dteg_pkg::MODE_WR_REL: begin
            if (idx < dteg_pkg::TABLE_SIZE)
               rel_tab[idx] = val;
         end
         default: begin
         end
      endcase
   endtask

   // Sample both channels and the register port on every rising edge.
   always @(posedge clock) begin
      gain_result_type oldest;
      if (reset) begin
         clear_envelope();
         awaited_gains.delete();
      end else begin
         // Register writes.
         if (csr_write) begin
            case (csr_index)
               dteg_pkg::CSR_ATTACK_STEP:  att_step  = csr_wdata[dteg_pkg::STEP_W-1:0];
               dteg_pkg::CSR_RELEASE_STEP: rel_step  = csr_wdata[dteg_pkg::STEP_W-1:0];
               dteg_pkg::CSR_SUSTAIN:      sus_level = csr_wdata[dteg_pkg::GAIN_W-1:0];
               default: begin
               end
            endcase
         end
         // Accepted request.
         if (req_valid && !req_stall)
            predict_request(req_mode, req_entry_index, req_entry_value);
         // Accepted response.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_gains.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual gain %0d ended %0d",
                        $time, rsp_gain, rsp_note_ended);
               fail_count++;
            end else begin
               oldest = awaited_gains.pop_front();
               if (rsp_gain !== oldest.gain) begin
                  $display("%0t: gain mismatch, expected %0d, actual %0d",
                           $time, oldest.gain, rsp_gain);
                  fail_count++;
               end
               if (rsp_note_ended !== oldest.ended) begin
                  $display("%0t: note_ended mismatch, expected %0d, actual %0d",
                           $time, oldest.ended, rsp_note_ended);
                  fail_count++;
               end
            end
         end
      end
      failures <= fail_count;
      pending  <= awaited_gains.size();
   end

endmodule

### bench/tb_drawn_table_envelope_generator_unit.sv
// Testbench top for the drawn-table envelope generator: stimulus, idling and verdict.
module tb_drawn_table_envelope_generator_unit;

   // Modes that the block ignores.
   localparam logic [dteg_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [dteg_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

   localparam logic [dteg_pkg::STEP_W-1:0] STEP_MAX = {dteg_pkg::STEP_W{1'b1}};
   localparam int                SETTINGS_NUM  = 8;
   localparam int                PHASE_ITEMS   = 75;
   localparam int                SETTLE_CYCLES = 48;
   localparam int                LIMIT_CYCLES  = 500000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [dteg_pkg::MODE_W-1:0]     req_mode = '0;
   logic [dteg_pkg::INDEX_W-1:0]    req_entry_index = '0;
   logic [dteg_pkg::GAIN_W-1:0]     req_entry_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [dteg_pkg::GAIN_W-1:0]     rsp_gain;
   logic                            rsp_note_ended;
   logic                            csr_write = 1'b0;
   logic [dteg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dteg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int  failures;
   int  pending;
   int  requests_sent = 0;
   int  phase_budget = PHASE_ITEMS;
   int  cycles = 0;
   bit  calm = 1'b0;

   logic [dteg_pkg::STEP_W-1:0] cur_att;
   logic [dteg_pkg::STEP_W-1:0] cur_rel;
   logic [dteg_pkg::STEP_W-1:0] att_cfg [SETTINGS_NUM];
   logic [dteg_pkg::STEP_W-1:0] rel_cfg [SETTINGS_NUM];
   logic [dteg_pkg::GAIN_W-1:0] sus_cfg [SETTINGS_NUM];

   drawn_table_envelope_generator_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gain        (rsp_gain),
      .rsp_note_ended  (rsp_note_ended),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   envelope_gain_checker i_gain_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gain        (rsp_gain),
      .rsp_note_ended  (rsp_note_ended),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending         (pending)
   );

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // The response side stalls now and then, except in the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 14);
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offers one request, sometimes after a gap, and waits until it is taken.
   task automatic send(input logic [dteg_pkg::MODE_W-1:0]  mode,
                       input logic [dteg_pkg::INDEX_W-1:0] idx,
                       input logic [dteg_pkg::GAIN_W-1:0]  val);
      if (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode < MODE_SPARE_A)
         requests_sent++;
   endtask

   // Ticks stop early once the request budget of the current stretch is spent.
   task automatic tick_times(input int n);
      repeat (n) begin
         if (requests_sent < phase_budget)
            send(dteg_pkg::MODE_TICK, dteg_pkg::INDEX_W'($urandom),
                 dteg_pkg::GAIN_W'($urandom));
      end
   endtask

   // Holds the sender back until every predicted response has come.
   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dteg_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [dteg_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Table values, weighted towards zero and full scale.
   function automatic logic [dteg_pkg::GAIN_W-1:0] random_gain();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return dteg_pkg::GAIN_MAX;
      return dteg_pkg::GAIN_W'($urandom);
   endfunction

   // Ticks to run a phase to its end with a little to spare, at most 60; a zero step gets 24.
   function automatic int tick_span(input logic [dteg_pkg::STEP_W-1:0] step);
      int span;
      if (step == '0)
         return 24;
      span = (dteg_pkg::TABLE_SIZE * 65536) / step + 3;
      return (span > 60) ? 60 : span;
   endfunction

   // One note with random content: table edits, sometimes a random mode, attack, then a soft or hard end.
   task automatic play_note();
      logic [dteg_pkg::MODE_W-1:0] noise_mode;
      repeat ($urandom_range(3)) begin
         send(($urandom_range(1) != 0) ? dteg_pkg::MODE_WR_ATT : dteg_pkg::MODE_WR_REL,
              dteg_pkg::INDEX_W'($urandom), random_gain());
      end
      if ($urandom_range(9) == 0) begin
         noise_mode = dteg_pkg::MODE_W'($urandom_range(MODE_SPARE_B, dteg_pkg::MODE_TICK));
         send(noise_mode, dteg_pkg::INDEX_W'($urandom), dteg_pkg::GAIN_W'($urandom));
      end
      send(dteg_pkg::MODE_NOTE_ON, dteg_pkg::INDEX_W'($urandom), dteg_pkg::GAIN_W'($urandom));
      tick_times($urandom_range(tick_span(cur_att)));
      if ($urandom_range(7) == 0) begin
         send(dteg_pkg::MODE_HARD_OFF, dteg_pkg::INDEX_W'($urandom),
              dteg_pkg::GAIN_W'($urandom));
      end else begin
         send(dteg_pkg::MODE_SOFT_OFF, dteg_pkg::INDEX_W'($urandom),
              dteg_pkg::GAIN_W'($urandom));
         tick_times($urandom_range(tick_span(cur_rel)));
      end
   endtask

   initial begin
      // Register settings: reset values, extremes, random mid-range ones, two with a zero step.
      att_cfg[0] = dteg_pkg::ATTACK_STEP_RST;
      rel_cfg[0] = dteg_pkg::RELEASE_STEP_RST;
      sus_cfg[0] = dteg_pkg::SUSTAIN_RST;
      att_cfg[1] = STEP_MAX;
      rel_cfg[1] = STEP_MAX;
      sus_cfg[1] = '0;
      att_cfg[2] = dteg_pkg::STEP_W'(1);
      rel_cfg[2] = dteg_pkg::STEP_W'(1);
      sus_cfg[2] = dteg_pkg::GAIN_MAX;
      for (int s = 3; s < SETTINGS_NUM; s++) begin
         att_cfg[s] = dteg_pkg::STEP_W'($urandom_range(1 << 21, 1 << 17));
         rel_cfg[s] = dteg_pkg::STEP_W'($urandom_range(1 << 21, 1 << 17));
         sus_cfg[s] = random_gain();
      end
      att_cfg[3] = '0;
      rel_cfg[4] = '0;
      cur_att    = dteg_pkg::ATTACK_STEP_RST;
      cur_rel    = dteg_pkg::RELEASE_STEP_RST;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings.
      tick_times(1);
      send(dteg_pkg::MODE_HARD_OFF, '0, '0);
      send(dteg_pkg::MODE_WR_ATT, '0, '0);
      send(dteg_pkg::MODE_WR_ATT, dteg_pkg::INDEX_W'(dteg_pkg::TABLE_SIZE - 1),
           dteg_pkg::GAIN_MAX);
      send(dteg_pkg::MODE_WR_ATT, dteg_pkg::INDEX_W'(2), dteg_pkg::GAIN_MAX);
      send(dteg_pkg::MODE_WR_REL, '0, dteg_pkg::GAIN_MAX);
      send(dteg_pkg::MODE_WR_REL, dteg_pkg::INDEX_W'(dteg_pkg::TABLE_SIZE - 1), '0);
      send(MODE_SPARE_A, {dteg_pkg::INDEX_W{1'b1}}, dteg_pkg::GAIN_MAX);
      send(MODE_SPARE_B, '0, '0);
      send(dteg_pkg::MODE_NOTE_ON, '0, '0);
      tick_times(4);
      // A retrigger keeps the table position.
      send(dteg_pkg::MODE_NOTE_ON, {dteg_pkg::INDEX_W{1'b1}}, dteg_pkg::GAIN_MAX);
      tick_times(2);
      send(dteg_pkg::MODE_SOFT_OFF, '0, '0);
      tick_times(3);
      send(dteg_pkg::MODE_HARD_OFF, {dteg_pkg::INDEX_W{1'b1}}, dteg_pkg::GAIN_MAX);
      tick_times(1);

      // Random notes under each register setting.
      for (int s = 0; s < SETTINGS_NUM; s++) begin
         if (s > 0) begin
            wait_results_done();
            repeat (SETTLE_CYCLES) @(posedge clock);
            write_csr(dteg_pkg::CSR_ATTACK_STEP, att_cfg[s]);
            write_csr(dteg_pkg::CSR_RELEASE_STEP, rel_cfg[s]);
            write_csr(dteg_pkg::CSR_SUSTAIN,
                      {(dteg_pkg::CSR_DATA_W - dteg_pkg::GAIN_W)'($urandom), sus_cfg[s]});
            csr_write <= 1'b0;
            cur_att = att_cfg[s];
            cur_rel = rel_cfg[s];
         end
         calm = (s == 5);
         phase_budget = (s + 1) * PHASE_ITEMS;
         while (requests_sent < phase_budget) begin
            play_note();
            // In the middle of one phase, let the block drain completely after each note.
            if (s == 6 && requests_sent >= s * PHASE_ITEMS + PHASE_ITEMS / 2
                && requests_sent < s * PHASE_ITEMS + PHASE_ITEMS / 2 + 40)
               wait_results_done();
         end
      end

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/dteg_pkg.sv
sv/dteg_ram.sv
sv/dteg_alu.sv
sv/drawn_table_envelope_generator_unit.sv
bench/envelope_gain_checker.sv
bench/tb_drawn_table_envelope_generator_unit.sv
